### rtl/eartm_pkg.sv
// eartm_pkg: shared types, widths and constants of the euler angle to
// rotation matrix block; no dependencies
`timescale 1ns / 1ps

package eartm_pkg;

  // field widths
  localparam int ANGLE_W = 16;
  localparam int ENTRY_W = 16;

  // cordic datapath widths: x/y in Q4.30, z in 2^-16 degree, sin/cos in Q20
  localparam int XY_W = 34;
  localparam int Z_W  = 25;
  localparam int SC_W = 22;
  localparam int RED_W = 18;

  // pipeline depth
  localparam int CORDIC_STEPS = 16;
  localparam int LANE_STAGES  = CORDIC_STEPS + 2;
  localparam int MAT_STAGES   = 4;
  localparam int PIPE_STAGES  = LANE_STAGES + MAT_STAGES;

  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // angles in 1/128 degree
  localparam logic signed [RED_W-1:0] DEG90  = 18'sd11520;
  localparam logic signed [RED_W-1:0] DEG180 = 18'sd23040;
  localparam logic signed [RED_W-1:0] DEG360 = 18'sd46080;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] pitch_angle;
    logic signed [ANGLE_W-1:0] roll_angle;
    logic signed [ANGLE_W-1:0] yaw_angle;
  } in_t;

  typedef struct packed {
    logic signed [ENTRY_W-1:0] m11;
    logic signed [ENTRY_W-1:0] m12;
    logic signed [ENTRY_W-1:0] m13;
    logic signed [ENTRY_W-1:0] m21;
    logic signed [ENTRY_W-1:0] m22;
    logic signed [ENTRY_W-1:0] m23;
    logic signed [ENTRY_W-1:0] m31;
    logic signed [ENTRY_W-1:0] m32;
    logic signed [ENTRY_W-1:0] m33;
  } out_t;

  // atan(2^-i) in degrees times 65536
  function automatic logic signed [Z_W-1:0] atan_q16(input logic [3:0] idx);
    logic signed [Z_W-1:0] r;
    case (idx)
      4'd0:  r = 25'sd2949120;
      4'd1:  r = 25'sd1740967;
      4'd2:  r = 25'sd919879;
      4'd3:  r = 25'sd466945;
      4'd4:  r = 25'sd234379;
      4'd5:  r = 25'sd117304;
      4'd6:  r = 25'sd58666;
      4'd7:  r = 25'sd29335;
      4'd8:  r = 25'sd14668;
      4'd9:  r = 25'sd7334;
      4'd10: r = 25'sd3667;
      4'd11: r = 25'sd1833;
      4'd12: r = 25'sd917;
      4'd13: r = 25'sd458;
      4'd14: r = 25'sd229;
      default: r = 25'sd115;
    endcase
    return r;
  endfunction

endpackage

### rtl/eartm_cordic_lane.sv
// eartm_cordic_lane: pipelined sine/cosine lane, range reduction, one
// cordic iteration per stage and Q20 rounding; depends on eartm_pkg
`timescale 1ns / 1ps

module eartm_cordic_lane (
  input  logic                                   clk_i,
  input  logic [eartm_pkg::LANE_STAGES-1:0]      en_i,
  input  logic signed [eartm_pkg::ANGLE_W-1:0]   angle_i,
  output logic signed [eartm_pkg::SC_W-1:0]      sin_o,
  output logic signed [eartm_pkg::SC_W-1:0]      cos_o
);

  localparam int XW = eartm_pkg::XY_W;
  localparam int ZW = eartm_pkg::Z_W;
  localparam int SW = eartm_pkg::SC_W;
  localparam int RW = eartm_pkg::RED_W;
  localparam int NS = eartm_pkg::CORDIC_STEPS;

  logic signed [XW-1:0] x_q [NS+1];
  logic signed [XW-1:0] y_q [NS+1];
  logic signed [ZW-1:0] z_q [NS+1];
  logic                 flip_q [NS+1];

  logic signed [RW-1:0] a_ext, a_wrap, a_fold;
  logic                 flip;
  logic signed [ZW-1:0] z_init;

  // wrap into +-180 degrees, then fold into +-90 degrees
  always_comb begin
    a_ext = RW'(angle_i);
    if (a_ext > eartm_pkg::DEG180) begin
      a_wrap = a_ext - eartm_pkg::DEG360;
    end else if (a_ext < -eartm_pkg::DEG180) begin
      a_wrap = a_ext + eartm_pkg::DEG360;
    end else begin
      a_wrap = a_ext;
    end
    flip = 1'b0;
    if (a_wrap > eartm_pkg::DEG90) begin
      a_fold = eartm_pkg::DEG180 - a_wrap;
      flip   = 1'b1;
    end else if (a_wrap < -eartm_pkg::DEG90) begin
      a_fold = -eartm_pkg::DEG180 - a_wrap;
      flip   = 1'b1;
    end else begin
      a_fold = a_wrap;
    end
    z_init = ZW'(a_fold) <<< 9;
  end

  // reduction stage register
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      x_q[0]    <= eartm_pkg::CORDIC_GAIN;
      y_q[0]    <= '0;
      z_q[0]    <= z_init;
      flip_q[0] <= flip;
    end
  end

  // one rotation per stage
  for (genvar g = 0; g < NS; g++) begin : g_step
    logic signed [XW-1:0] dx, dy;
    logic signed [ZW-1:0] t;
    assign dx = y_q[g] >>> g;
    assign dy = x_q[g] >>> g;
    assign t  = eartm_pkg::atan_q16(4'(g));

    always_ff @(posedge clk_i) begin
      if (en_i[g+1]) begin
        if (!z_q[g][ZW-1]) begin
          x_q[g+1] <= x_q[g] - dx;
          y_q[g+1] <= y_q[g] + dy;
          z_q[g+1] <= z_q[g] - t;
        end else begin
          x_q[g+1] <= x_q[g] + dx;
          y_q[g+1] <= y_q[g] - dy;
          z_q[g+1] <= z_q[g] + t;
        end
        flip_q[g+1] <= flip_q[g];
      end
    end
  end

  // round to Q20 and restore the cosine sign
  logic signed [XW-1:0] s_rnd, c_rnd;
  logic signed [SW-1:0] c_d;
  always_comb begin
    s_rnd = (y_q[NS] + XW'(512)) >>> 10;
    c_rnd = (x_q[NS] + XW'(512)) >>> 10;
    c_d   = flip_q[NS] ? -c_rnd[SW-1:0] : c_rnd[SW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[NS+1]) begin
      sin_o <= s_rnd[SW-1:0];
      cos_o <= c_d;
    end
  end

endmodule

### rtl/eartm_matrix.sv
// eartm_matrix: merges the three lanes' sine/cosine into the nine matrix
// entries over four registered stages; depends on eartm_pkg
`timescale 1ns / 1ps

module eartm_matrix (
  input  logic                              clk_i,
  input  logic [eartm_pkg::MAT_STAGES-1:0]  en_i,
  input  logic signed [eartm_pkg::SC_W-1:0] sp_i,
  input  logic signed [eartm_pkg::SC_W-1:0] cp_i,
  input  logic signed [eartm_pkg::SC_W-1:0] sr_i,
  input  logic signed [eartm_pkg::SC_W-1:0] cr_i,
  input  logic signed [eartm_pkg::SC_W-1:0] sy_i,
  input  logic signed [eartm_pkg::SC_W-1:0] cy_i,
  output eartm_pkg::out_t                   data_o
);

  localparam int SW = eartm_pkg::SC_W;
  localparam int PW = 2 * SW;
  localparam int HW = PW - 21;
  localparam int EW = 64;

  function automatic logic signed [eartm_pkg::ENTRY_W-1:0] to_q15(
    input logic signed [EW-1:0] v);
    logic signed [EW-1:0] r;
    logic signed [eartm_pkg::ENTRY_W-1:0] o;
    r = (v + (EW'(1) <<< 44)) >>> 45;
    if (r > EW'(32767)) begin
      o = 16'sh7fff;
    end else if (r < -EW'(32768)) begin
      o = 16'sh8000;
    end else begin
      o = r[eartm_pkg::ENTRY_W-1:0];
    end
    return o;
  endfunction

  // stage 1: pair products in Q40
  logic signed [PW-1:0] cpcy_q, cpsy_q, srsp_q, crsp_q, crsy_q;
  logic signed [PW-1:0] crcy_q, srcp_q, srsy_q, srcy_q, crcp_q;
  logic signed [SW-1:0] sp1_q, sy1_q, cy1_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      cpcy_q <= cp_i * cy_i;
      cpsy_q <= cp_i * sy_i;
      srsp_q <= sr_i * sp_i;
      crsp_q <= cr_i * sp_i;
      crsy_q <= cr_i * sy_i;
      crcy_q <= cr_i * cy_i;
      srcp_q <= sr_i * cp_i;
      srsy_q <= sr_i * sy_i;
      srcy_q <= sr_i * cy_i;
      crcp_q <= cr_i * cp_i;
      sp1_q  <= sp_i;
      sy1_q  <= sy_i;
      cy1_q  <= cy_i;
    end
  end

  // stage 2: triple products split into high and low partial products
  logic signed [HW+SW-1:0] h21_q, h22_q, h31_q, h32_q;
  logic signed [PW-1:0]    l21_q, l22_q, l31_q, l32_q;
  logic signed [PW-1:0]    cpcy2_q, cpsy2_q, crsy2_q, crcy2_q;
  logic signed [PW-1:0]    srcp2_q, srsy2_q, srcy2_q, crcp2_q;
  logic signed [SW-1:0]    sp2_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      h21_q   <= $signed(srsp_q[PW-1:21]) * cy1_q;
      l21_q   <= $signed({1'b0, srsp_q[20:0]}) * cy1_q;
      h22_q   <= $signed(srsp_q[PW-1:21]) * sy1_q;
      l22_q   <= $signed({1'b0, srsp_q[20:0]}) * sy1_q;
      h31_q   <= $signed(crsp_q[PW-1:21]) * cy1_q;
      l31_q   <= $signed({1'b0, crsp_q[20:0]}) * cy1_q;
      h32_q   <= $signed(crsp_q[PW-1:21]) * sy1_q;
      l32_q   <= $signed({1'b0, crsp_q[20:0]}) * sy1_q;
      cpcy2_q <= cpcy_q;
      cpsy2_q <= cpsy_q;
      crsy2_q <= crsy_q;
      crcy2_q <= crcy_q;
      srcp2_q <= srcp_q;
      srsy2_q <= srsy_q;
      srcy2_q <= srcy_q;
      crcp2_q <= crcp_q;
      sp2_q   <= sp1_q;
    end
  end

  // stage 3: exact entries in Q60
  logic signed [EW-1:0] t21, t22, t31, t32;
  logic signed [EW-1:0] e_d [9];
  logic signed [EW-1:0] e_q [9];

  always_comb begin
    t21 = (EW'(h21_q) <<< 21) + EW'(l21_q);
    t22 = (EW'(h22_q) <<< 21) + EW'(l22_q);
    t31 = (EW'(h31_q) <<< 21) + EW'(l31_q);
    t32 = (EW'(h32_q) <<< 21) + EW'(l32_q);
    e_d[0] = EW'(cpcy2_q) <<< 20;
    e_d[1] = -(EW'(cpsy2_q) <<< 20);
    e_d[2] = EW'(sp2_q) <<< 40;
    e_d[3] = t21 + (EW'(crsy2_q) <<< 20);
    e_d[4] = (EW'(crcy2_q) <<< 20) - t22;
    e_d[5] = -(EW'(srcp2_q) <<< 20);
    e_d[6] = (EW'(srsy2_q) <<< 20) - t31;
    e_d[7] = t32 + (EW'(srcy2_q) <<< 20);
    e_d[8] = EW'(crcp2_q) <<< 20;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      e_q <= e_d;
    end
  end

  // stage 4: round to Q15 and saturate, this is the output register
  eartm_pkg::out_t out_d;
  always_comb begin
    out_d.m11 = to_q15(e_q[0]);
    out_d.m12 = to_q15(e_q[1]);
    out_d.m13 = to_q15(e_q[2]);
    out_d.m21 = to_q15(e_q[3]);
    out_d.m22 = to_q15(e_q[4]);
    out_d.m23 = to_q15(e_q[5]);
    out_d.m31 = to_q15(e_q[6]);
    out_d.m32 = to_q15(e_q[7]);
    out_d.m33 = to_q15(e_q[8]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      data_o <= out_d;
    end
  end

endmodule

### rtl/euler_angles_to_rotation_matrix_core.sv
// Euler angles (pitch, roll, yaw in 1/128 degree) to rotation matrix
// R = Rx(roll)*Ry(pitch)*Rz(yaw) in Q1.15; depends on eartm_pkg,
// eartm_cordic_lane and eartm_matrix
//
// Usage:
//   Input channel: in_valid_i / in_stall_o carry one angle triple per beat.
//   Output channel: out_valid_o / out_stall_i carry the nine entries per beat.
//   Three cordic lanes, one per angle, run side by side with one rotation per
//   pipeline stage; a four-stage merge forms the products and rounds them.
//   Throughput: one beat per cycle while the receiver does not stall;
//   each stage holds its own valid bit.
//   When the receiver stalls, the output register holds its beat and the
//   stages behind it keep filling empty slots; in_stall_o rises only when
//   every stage up to the input holds a beat that cannot move.
//   Reset clears all valid bits; payload registers are not reset.
`timescale 1ns / 1ps

module euler_angles_to_rotation_matrix_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  eartm_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output eartm_pkg::out_t out_data_o
);

  localparam int NS = eartm_pkg::PIPE_STAGES;
  localparam int LS = eartm_pkg::LANE_STAGES;

  logic [NS-1:0] v_q, v_d, en;

  // per-stage advance: a stage loads when it is empty or its successor moves
  always_comb begin
    en[NS-1] = !v_q[NS-1] || !out_stall_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d[0] = en[0] ? in_valid_i : v_q[0];
    for (int k = 1; k < NS; k++) begin
      v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[NS-1];

  // sine/cosine lanes
  logic signed [eartm_pkg::SC_W-1:0] sp, cp, sr, cr, sy, cy;

  eartm_cordic_lane u_lane_pitch (
    .clk_i   (clk_i),
    .en_i    (en[LS-1:0]),
    .angle_i (in_data_i.pitch_angle),
    .sin_o   (sp),
    .cos_o   (cp)
  );

  eartm_cordic_lane u_lane_roll (
    .clk_i   (clk_i),
    .en_i    (en[LS-1:0]),
    .angle_i (in_data_i.roll_angle),
    .sin_o   (sr),
    .cos_o   (cr)
  );

  eartm_cordic_lane u_lane_yaw (
    .clk_i   (clk_i),
    .en_i    (en[LS-1:0]),
    .angle_i (in_data_i.yaw_angle),
    .sin_o   (sy),
    .cos_o   (cy)
  );

  // merge into the matrix
  eartm_matrix u_matrix (
    .clk_i  (clk_i),
    .en_i   (en[NS-1:LS]),
    .sp_i   (sp),
    .cp_i   (cp),
    .sr_i   (sr),
    .cr_i   (cr),
    .sy_i   (sy),
    .cy_i   (cy),
    .data_o (out_data_o)
  );

endmodule

### rtl/eartm_checker.sv
// eartm_checker: port-level assertions for the rotation matrix core and
// the bind that attaches them; depends on eartm_pkg
`timescale 1ns / 1ps

module eartm_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_stall_o,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input eartm_pkg::out_t out_data_o
);

  // a stalled output beat stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped under stall");

  // a stalled output beat keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output payload changed under stall");

  // an empty output register never backs up the input
  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // a free receiver never backs up the input
  a_free_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output drains");

endmodule

bind euler_angles_to_rotation_matrix_core eartm_checker u_eartm_checker (.*);
